>>> hw/rtl/timed_control_schedule_table_top_macros.svh
// ----------------------------------------------------------------------------
// Timed control schedule table - assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TIMED_CONTROL_SCHEDULE_TABLE_TOP_MACROS_SVH
`define TIMED_CONTROL_SCHEDULE_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define TCST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcst: property failed");

// next-cycle implication
`define TCST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcst: property failed");

`endif

>>> hw/rtl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// Timed control schedule table - package
// Field widths, codes and the stored entry type.
// ----------------------------------------------------------------------------
package tcst_pkg;

    localparam int ENTRIES_DEFAULT = 64;

    localparam int TIME_W   = 32;
    localparam int WELL_W   = 10;
    localparam int KIND_W   = 3;
    localparam int AMOUNT_W = 32;
    localparam int STATUS_W = 2;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_TOTAL_FLOW = 3'd1;

    typedef struct packed {
        logic [TIME_W-1:0]          evt_time;
        logic [WELL_W-1:0]          well;
        logic [KIND_W-1:0]          kind;
        logic signed [AMOUNT_W-1:0] amount;
        logic signed [AMOUNT_W-1:0] skin;
    } t_entry;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctrl;

endpackage

>>> hw/rtl/tcst_if.sv
// ----------------------------------------------------------------------------
// Timed control schedule table - stream interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcst_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    mode;
    logic [tcst_pkg::TIME_W-1:0]             event_time;
    logic [tcst_pkg::WELL_W-1:0]             well_number;
    logic [tcst_pkg::KIND_W-1:0]             control_kind;
    logic signed [tcst_pkg::AMOUNT_W-1:0]    control_amount;
    logic signed [tcst_pkg::AMOUNT_W-1:0]    skin_factor;

    modport source (
        output valid, mode, event_time, well_number, control_kind,
               control_amount, skin_factor,
        input  ready
    );
    modport sink (
        input  valid, mode, event_time, well_number, control_kind,
               control_amount, skin_factor,
        output ready
    );
endinterface

interface tcst_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [tcst_pkg::STATUS_W-1:0]           status;
    logic [tcst_pkg::KIND_W-1:0]             found_kind;
    logic signed [tcst_pkg::AMOUNT_W-1:0]    found_amount;
    logic signed [tcst_pkg::AMOUNT_W-1:0]    found_skin;

    modport source (
        output valid, status, found_kind, found_amount, found_skin,
        input  ready
    );
    modport sink (
        input  valid, status, found_kind, found_amount, found_skin,
        output ready
    );
endinterface

>>> hw/rtl/tcst_store.sv
// ----------------------------------------------------------------------------
// Timed control schedule table - entry store
// Single write, single registered read memory of schedule entries.
// ----------------------------------------------------------------------------
module tcst_store #(
    parameter int ENTRIES = tcst_pkg::ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                 i_clk,
    input  tcst_pkg::t_mem_ctrl  i_ctrl,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  tcst_pkg::t_entry     i_wr_data,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output tcst_pkg::t_entry     o_rd_data
);
    import tcst_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/timed_control_schedule_table_top.sv
// ----------------------------------------------------------------------------
// Timed control schedule table - top level
// Appends timed control entries and looks up the control in force for a well.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. An append goes from its beat to its
// result beat by way of the store, then the result register. A query scans
// its entries one per cycle from the single-read entry memory, starting at
// the oldest, and stops after the first entry later than the query time or
// after the last stored entry, so it reads at most the entry count of entries.
// A query on an empty table reads no entry. The memory needs no clearing
// after reset; only entries below the entry count are ever read. The result
// register lets a finished result wait while the next request is taken.
module timed_control_schedule_table_top #(
    parameter int ENTRIES = tcst_pkg::ENTRIES_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcst_in_if.sink       i_in,
    tcst_out_if.source    o_out
);
    import tcst_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [TIME_W-1:0]      r_q_time, n_q_time;
    logic [WELL_W-1:0]      r_q_well, n_q_well;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [AMOUNT_W-1:0]    r_amount, n_amount;
    logic [AMOUNT_W-1:0]    r_skin, n_skin;
    logic                   r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]    r_o_status, n_o_status;
    logic [KIND_W-1:0]      r_o_kind, n_o_kind;
    logic [AMOUNT_W-1:0]    r_o_amount, n_o_amount;
    logic [AMOUNT_W-1:0]    r_o_skin, n_o_skin;

    t_mem_ctrl              mem_ctrl;
    t_entry                 wr_data;
    t_entry                 rd_data;
    logic [IDX_W-1:0]       rd_addr;

    assign wr_data.evt_time = i_in.event_time;
    assign wr_data.well     = i_in.well_number;
    assign wr_data.kind     = i_in.control_kind;
    assign wr_data.amount   = i_in.control_amount;
    assign wr_data.skin     = i_in.skin_factor;

    tcst_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctrl    (mem_ctrl),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_o_status;
    assign o_out.found_kind   = r_o_kind;
    assign o_out.found_amount = r_o_amount;
    assign o_out.found_skin   = r_o_skin;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_q_time    = r_q_time;
        n_q_well    = r_q_well;
        n_status    = r_status;
        n_kind      = r_kind;
        n_amount    = r_amount;
        n_skin      = r_skin;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_kind    = r_o_kind;
        n_o_amount  = r_o_amount;
        n_o_skin    = r_o_skin;
        mem_ctrl    = '0;
        rd_addr     = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_q_time = i_in.event_time;
                    n_q_well = i_in.well_number;
                    n_status = STATUS_OK;
                    n_kind   = '0;
                    n_amount = '0;
                    n_skin   = '0;
                    n_state  = S_EMIT;
                    if (i_in.mode == MODE_APPEND) begin
                        if (r_count == CNT_W'(ENTRIES)) begin
                            n_status = STATUS_FULL;
                        end else begin
                            mem_ctrl.wr_en = 1'b1;
                            n_count        = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = STATUS_EMPTY;
                    end else begin
                        n_kind         = KIND_TOTAL_FLOW;
                        n_idx          = '0;
                        mem_ctrl.rd_en = 1'b1;
                        rd_addr        = '0;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_data.evt_time > r_q_time) begin
                    n_state = S_EMIT;
                end else begin
                    if (rd_data.well == r_q_well) begin
                        n_kind   = rd_data.kind;
                        n_amount = rd_data.amount;
                        n_skin   = rd_data.skin;
                    end
                    if (r_idx + CNT_W'(1) == r_count) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx          = r_idx + CNT_W'(1);
                        mem_ctrl.rd_en = 1'b1;
                        rd_addr        = n_idx[IDX_W-1:0];
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_kind    = r_kind;
                    n_o_amount  = r_amount;
                    n_o_skin    = r_skin;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_q_time   <= n_q_time;
        r_q_well   <= n_q_well;
        r_status   <= n_status;
        r_kind     <= n_kind;
        r_amount   <= n_amount;
        r_skin     <= n_skin;
        r_o_status <= n_o_status;
        r_o_kind   <= n_o_kind;
        r_o_amount <= n_o_amount;
        r_o_skin   <= n_o_skin;
    end

endmodule

>>> hw/rtl/tcst_checker.sv
// ----------------------------------------------------------------------------
// Timed control schedule table - port checker
// Properties on the request and result ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "timed_control_schedule_table_top_macros.svh"

module tcst_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic [tcst_pkg::STATUS_W-1:0]         i_status,
    input  logic [tcst_pkg::KIND_W-1:0]           i_found_kind,
    input  logic [tcst_pkg::AMOUNT_W-1:0]         i_found_amount,
    input  logic [tcst_pkg::AMOUNT_W-1:0]         i_found_skin
);
    import tcst_pkg::*;

    // one request in flight at a time
    `TCST_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // stalled result holds
    `TCST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_found_kind) && $stable(i_found_amount) && $stable(i_found_skin))

    // error results carry no control
    `TCST_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_out_valid && (i_status == STATUS_EMPTY || i_status == STATUS_FULL), i_found_kind == '0 && i_found_amount == '0 && i_found_skin == '0)

endmodule

bind timed_control_schedule_table_top tcst_checker u_tcst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_found_kind   (o_out.found_kind),
    .i_found_amount (o_out.found_amount),
    .i_found_skin   (o_out.found_skin)
);

>>> bench/tcst_control_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed control schedule table - checker
// Watches the request and result channels. It keeps its own copy of the
// schedule table and works out the control in force for every accepted
// request. Each result beat is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module tcst_control_checker #(
    parameter int ENTRIES = tcst_pkg::ENTRIES_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tcst_in_if      i_in,
    tcst_out_if     i_out,
    output int      o_fail_count,
    output int      o_pending
);
    import tcst_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic [KIND_W-1:0]          kind;
        logic signed [AMOUNT_W-1:0] amount;
        logic signed [AMOUNT_W-1:0] skin;
    } t_control_result;

    t_entry          schedule_rows [ENTRIES];
    int unsigned     row_count = 0;
    t_control_result controls_due [$];
    int              mismatches = 0;
    int              pending_q = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_q;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    // stores an append, or scans the table up to the query time
    function automatic t_control_result apply_schedule_request(
        input logic                   mode,
        input logic [TIME_W-1:0]      when_q,
        input logic [WELL_W-1:0]      well,
        input logic [KIND_W-1:0]      kind,
        input logic signed [AMOUNT_W-1:0] amount,
        input logic signed [AMOUNT_W-1:0] skin
    );
        t_control_result res;
        int unsigned     idx;
        bit              stopped;
        res     = '0;
        stopped = 1'b0;
        res.status = STATUS_OK;
        if (mode == MODE_APPEND) begin
            if (row_count >= ENTRIES) begin
                res.status = STATUS_FULL;
            end else begin
                schedule_rows[row_count].evt_time = when_q;
                schedule_rows[row_count].well     = well;
                schedule_rows[row_count].kind     = kind;
                schedule_rows[row_count].amount   = amount;
                schedule_rows[row_count].skin     = skin;
                row_count++;
            end
        end else if (row_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.kind = KIND_TOTAL_FLOW;
            for (idx = 0; idx < row_count && !stopped; idx++) begin
                if (schedule_rows[idx].evt_time > when_q) begin
                    stopped = 1'b1;
                end else if (schedule_rows[idx].well == well) begin
                    res.kind   = schedule_rows[idx].kind;
                    res.amount = schedule_rows[idx].amount;
                    res.skin   = schedule_rows[idx].skin;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_control_result want;
        t_control_result fresh;
        if (!i_rst_n) begin
            row_count = 0;
            controls_due.delete();
            pending_q <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (controls_due.size() == 0) begin
                    report_mismatch("unexpected result status", 32'(i_out.status), 32'h0);
                end else begin
                    want = controls_due.pop_front();
                    if (i_out.status !== want.status)
                        report_mismatch("status", 32'(i_out.status), 32'(want.status));
                    if (i_out.found_kind !== want.kind)
                        report_mismatch("found_kind", 32'(i_out.found_kind),
                                        32'(want.kind));
                    if (i_out.found_amount !== want.amount)
                        report_mismatch("found_amount", i_out.found_amount, want.amount);
                    if (i_out.found_skin !== want.skin)
                        report_mismatch("found_skin", i_out.found_skin, want.skin);
                end
            end
            if (i_in.valid && i_in.ready) begin
                fresh = apply_schedule_request(i_in.mode, i_in.event_time,
                    i_in.well_number, i_in.control_kind, i_in.control_amount,
                    i_in.skin_factor);
                controls_due = {controls_due, fresh};
            end
            pending_q <= controls_due.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed control schedule table - testbench top
// Drives appends and queries with random gaps and result stalls: a directed
// run through the corner cases, then schedules of rising times with queries
// aimed at stored times and wells, plus noise. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import tcst_pkg::*;

    localparam int TABLE_DEPTH  = ENTRIES_DEFAULT;
    localparam int RANDOM_ITEMS = 900;

    localparam logic [KIND_W-1:0] KIND_PRESSURE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WATER      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OIL        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GAS        = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_HI = 3'd7;

    typedef struct {
        logic                       mode;
        logic [TIME_W-1:0]          evt_time;
        logic [WELL_W-1:0]          well;
        logic [KIND_W-1:0]          kind;
        logic signed [AMOUNT_W-1:0] amount;
        logic signed [AMOUNT_W-1:0] skin;
    } t_request;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    bit   steady = 1'b0;
    int   rx_hold_cycles = 0;

    // stimulus-side view of the schedule, used only to aim queries
    logic [TIME_W-1:0] sched_time [TABLE_DEPTH];
    logic [WELL_W-1:0] sched_well [TABLE_DEPTH];
    int                sched_count = 0;
    logic [TIME_W-1:0] next_time = '0;
    logic [WELL_W-1:0] well_pool [4];

    tcst_in_if  u_in ();
    tcst_out_if u_out ();

    timed_control_schedule_table_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out)
    );

    tcst_control_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (u_in),
        .i_out        (u_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int draw_wait();
        if (steady)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    function automatic t_request request_of(input logic mode, input logic [TIME_W-1:0] t,
                                            input logic [WELL_W-1:0] well,
                                            input logic [KIND_W-1:0] kind,
                                            input logic [AMOUNT_W-1:0] amount,
                                            input logic [AMOUNT_W-1:0] skin);
        t_request req;
        req.mode     = mode;
        req.evt_time = t;
        req.well     = well;
        req.kind     = kind;
        req.amount   = amount;
        req.skin     = skin;
        return req;
    endfunction

    function automatic logic [WELL_W-1:0] pick_well();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0 || sched_count == 0)
            return WELL_W'($urandom);
        if (sel < 3)
            return well_pool[$urandom_range(0, 3)];
        return sched_well[$urandom_range(0, sched_count - 1)];
    endfunction

    function automatic t_request random_request();
        t_request req;
        int       sel;
        int       pick;
        int       append_pct;
        req.mode     = MODE_QUERY;
        req.evt_time = $urandom;
        req.well     = WELL_W'($urandom);
        req.kind     = KIND_W'($urandom);
        req.amount   = $urandom;
        req.skin     = $urandom;
        append_pct   = (sched_count < TABLE_DEPTH) ? 35 : 15;
        sel          = $urandom_range(0, 99);
        if (sel < 5) begin
            req.mode = MODE_W_RANDOM();
        end else if (sel < append_pct) begin
            req.mode = MODE_APPEND;
            if ($urandom_range(0, 9) != 0) begin
                next_time    = next_time + TIME_W'($urandom_range(0, 1024));
                req.evt_time = next_time;
            end
            req.well = ($urandom_range(0, 4) == 0) ? WELL_W'($urandom)
                                                    : well_pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 4) != 0)
                req.kind = KIND_W'($urandom_range(KIND_PRESSURE, KIND_GAS));
        end else begin
            if (sched_count > 0 && $urandom_range(0, 9) != 0) begin
                pick = $urandom_range(0, sched_count - 1);
                case ($urandom_range(0, 3))
                    0: req.evt_time = sched_time[pick];
                    1: req.evt_time = sched_time[pick] - 1'b1;
                    2: req.evt_time = sched_time[pick] + 1'b1;
                    default: req.evt_time = sched_time[pick] + TIME_W'($urandom_range(0, 255));
                endcase
            end
            req.well = pick_well();
        end
        return req;
    endfunction

    function automatic logic MODE_W_RANDOM();
        return ($urandom_range(0, 1) == 0) ? MODE_APPEND : MODE_QUERY;
    endfunction

    task automatic push_request(input t_request req);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            u_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        u_in.valid          <= 1'b1;
        u_in.mode           <= req.mode;
        u_in.event_time     <= req.evt_time;
        u_in.well_number    <= req.well;
        u_in.control_kind   <= req.kind;
        u_in.control_amount <= req.amount;
        u_in.skin_factor    <= req.skin;
        do @(posedge i_clk); while (!u_in.ready);
        if (req.mode == MODE_APPEND && sched_count < TABLE_DEPTH) begin
            sched_time[sched_count] = req.evt_time;
            sched_well[sched_count] = req.well;
            sched_count++;
        end
    endtask

    // sender pauses until every outstanding result has been taken
    task automatic drain_results();
        u_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : result_sink
        int stall;
        u_out.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = draw_wait();
            end
            if (stall > 0) begin
                u_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            u_out.ready <= 1'b1;
            do @(posedge i_clk); while (!u_out.valid);
        end
    end

    initial begin : stimulus
        int n;
        i_rst_n             <= 1'b0;
        u_in.valid          <= 1'b0;
        u_in.mode           <= MODE_APPEND;
        u_in.event_time     <= '0;
        u_in.well_number    <= '0;
        u_in.control_kind   <= '0;
        u_in.control_amount <= '0;
        u_in.skin_factor    <= '0;
        for (n = 0; n < 4; n++)
            well_pool[n] = WELL_W'($urandom);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes, unknown kinds, unsorted times, equal times
        push_request(request_of(MODE_QUERY, 32'h0000_0100, 10'd5, KIND_GAS,
                                32'h1234_5678, 32'h8765_4321));
        push_request(request_of(MODE_APPEND, 32'h0000_0000, 10'd0, KIND_PRESSURE,
                                32'h8000_0000, 32'h7FFF_FFFF));
        push_request(request_of(MODE_APPEND, 32'h0000_0100, 10'd1023, KIND_GAS,
                                32'h7FFF_FFFF, 32'h8000_0000));
        push_request(request_of(MODE_APPEND, 32'h0000_0200, 10'd0, KIND_UNKNOWN_HI,
                                32'hFFFF_FFFF, 32'h0000_0001));
        push_request(request_of(MODE_APPEND, 32'h0000_0180, 10'd1023, KIND_UNKNOWN_LO,
                                32'h0001_0000, 32'hFFFF_0000));
        push_request(request_of(MODE_APPEND, 32'hFFFF_FFFF, 10'd0, KIND_WATER,
                                32'h7FFF_0000, 32'h0000_8000));
        push_request(request_of(MODE_QUERY, 32'h0000_0000, 10'd0, KIND_PRESSURE, '0, '0));
        push_request(request_of(MODE_QUERY, 32'h0000_0000, 10'd1023, KIND_PRESSURE, '0, '0));
        push_request(request_of(MODE_QUERY, 32'h0000_0100, 10'd1023, KIND_PRESSURE, '0, '0));
        push_request(request_of(MODE_QUERY, 32'h0000_01FF, 10'd1023, KIND_PRESSURE, '0, '0));
        push_request(request_of(MODE_QUERY, 32'h0000_0200, 10'd1023, KIND_PRESSURE, '0, '0));
        push_request(request_of(MODE_QUERY, 32'h0000_0200, 10'd0, KIND_PRESSURE, '0, '0));
        push_request(request_of(MODE_QUERY, 32'hFFFF_FFFF, 10'd0, KIND_PRESSURE, '0, '0));
        push_request(request_of(MODE_QUERY, 32'hFFFF_FFFF, 10'd512, KIND_PRESSURE, '0, '0));
        push_request(request_of(MODE_APPEND, 32'hFFFF_FFFF, 10'd512, KIND_OIL,
                                32'h0000_0000, 32'h0000_0000));
        push_request(request_of(MODE_QUERY, 32'hFFFF_FFFF, 10'd512, KIND_PRESSURE, '0, '0));
        push_request(request_of(MODE_QUERY, 32'h0000_017F, 10'd1023, KIND_UNKNOWN_HI,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF));
        push_request(request_of(MODE_APPEND, 32'h0000_0300, 10'd1, 3'd6,
                                32'h5555_5555, 32'hAAAA_AAAA));
        push_request(request_of(MODE_QUERY, 32'h0000_0300, 10'd1, KIND_PRESSURE, '0, '0));
        drain_results();

        next_time = 32'h0000_0400;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                steady = ((n / 100) % 3 == 1);
            if (n == 300) begin
                steady         = 1'b1;
                rx_hold_cycles = 250;
            end
            if (n == 600)
                drain_results();
            push_request(random_request());
        end
        drain_results();
        repeat (80) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> timed_control_schedule_table_top.f
+incdir+hw/rtl
hw/rtl/tcst_pkg.sv
hw/rtl/tcst_if.sv
hw/rtl/tcst_store.sv
hw/rtl/timed_control_schedule_table_top.sv
hw/rtl/tcst_checker.sv
bench/tcst_control_checker.sv
bench/tb.sv
